### design/gcb_pkg.sv
package gcb_pkg;

	localparam int AMOUNT_BITS = 24;
	localparam int NUM_DENOMS  = 15;
	localparam int FIRST_COIN  = 7;
	localparam int N_SMALL     = NUM_DENOMS - 1;
	localparam int IDX_W       = $clog2(NUM_DENOMS);
	localparam int DEN_W       = 16;
	localparam int CNT_W       = 17;
	localparam int REST_W      = 16;
	localparam int REM_W       = 17;
	localparam int QUO_W       = AMOUNT_BITS - 7;
	localparam int PROD_W      = AMOUNT_BITS + QUO_W;
	localparam int QD_W        = QUO_W + DEN_W;

	localparam logic [DEN_W-1:0] DENOM [NUM_DENOMS] = '{
		16'd50000, 16'd20000, 16'd10000, 16'd5000, 16'd2000, 16'd1000, 16'd500,
		16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1
	};

	localparam logic [QUO_W-1:0] RECIP_NOTE =
		QUO_W'((64'd1 << AMOUNT_BITS) / 64'd50000);
	localparam logic [QUO_W-1:0] RECIP_COIN =
		QUO_W'((64'd1 << AMOUNT_BITS) / 64'd200);

	typedef struct packed {
		logic                      mode;
		logic [CNT_W-1:0]          cnt0;
		logic [N_SMALL-1:0][1:0]   cnt_small;
		logic [REST_W-1:0]         rest;
		logic [CNT_W-1:0]          total;
		logic [1:0]                best_cnt;
		logic [DEN_W-1:0]          best_denom;
	} gcb_word_t;

endpackage

### design/greedy_change_breakdown_core.sv
// channel | fields                                                     | handshake
// in      | amount_cents, mode                                         | in_valid / in_stall
// out     | denom_cents, piece_count, last_flag, total_pieces,         | out_valid / out_stall
//         | most_frequent_cents                                        |
//
// an amount can enter every cycle while the serializer keeps up; it passes through the
// divider registers and the denomination stages and then drives 1 word per
// denomination used (1 word for zero), one word a cycle unless out_stall holds, so
// an amount yields 1 to 15 words on the result port
// reset clears valid bits and the result serializer; no clearing pass
// a word waiting at the chain end while the serializer is busy (out_stall, or more words
// left for the current amount) freezes the divider and chain stages and raises in_stall
module greedy_change_breakdown_core import gcb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [AMOUNT_BITS-1:0] amount_cents,
	input  logic                   mode,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [DEN_W-1:0]       denom_cents,
	output logic [CNT_W-1:0]       piece_count,
	output logic                   last_flag,
	output logic [CNT_W-1:0]       total_pieces,
	output logic [DEN_W-1:0]       most_frequent_cents
);

	logic      adv;
	logic      take;
	logic      div_v, chain_v;
	gcb_word_t div_w, chain_w;

	assign adv      = !chain_v || take;
	assign in_stall = !adv;

	gcb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.amount   (amount_cents),
		.mode     (mode),
		.v_out    (div_v),
		.w_out    (div_w)
	);

	gcb_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (div_v),
		.w_in   (div_w),
		.v_out  (chain_v),
		.w_out  (chain_w)
	);

	gcb_emit u_emit (
		.clk                 (clk),
		.arst_n              (arst_n),
		.v_in                (chain_v),
		.w_in                (chain_w),
		.take                (take),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.denom_cents         (denom_cents),
		.piece_count         (piece_count),
		.last_flag           (last_flag),
		.total_pieces        (total_pieces),
		.most_frequent_cents (most_frequent_cents)
	);

endmodule

### design/gcb_div.sv
module gcb_div import gcb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  logic [AMOUNT_BITS-1:0] amount,
	input  logic                   mode,
	output logic                   v_out,
	output gcb_word_t              w_out
);

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic [PROD_W-1:0]      prod_s1;
	logic [AMOUNT_BITS-1:0] amount_s1, amount_s2;
	logic                   mode_s1, mode_s2, mode_s3;
	logic [QUO_W-1:0]       quo_s2, quo_s3;
	logic [QD_W-1:0]        qd_s2;
	logic [REM_W-1:0]       rem_s3;
	gcb_word_t              word_s4;

	logic [PROD_W-1:0]      prod_c;
	logic [QUO_W-1:0]       quo_c;
	logic [QD_W-1:0]        qd_c;
	logic [AMOUNT_BITS-1:0] diff_c;
	logic [DEN_W-1:0]       d0_s1, d0_s3;
	logic [QUO_W-1:0]       quo_fix;
	logic [REM_W-1:0]       rem_fix;
	gcb_word_t              word_c;

	assign prod_c = PROD_W'(amount) * PROD_W'(mode ? RECIP_NOTE : RECIP_COIN);
	assign quo_c  = prod_s1[PROD_W-1:AMOUNT_BITS];
	assign d0_s1  = mode_s1 ? DENOM[0] : DENOM[FIRST_COIN];
	assign qd_c   = QD_W'(quo_c) * QD_W'(d0_s1);
	assign diff_c = amount_s2 - qd_s2[AMOUNT_BITS-1:0];
	assign d0_s3  = mode_s3 ? DENOM[0] : DENOM[FIRST_COIN];

	// at most one correction step after the reciprocal estimate
	always_comb begin
		if (rem_s3 >= REM_W'(d0_s3)) begin
			quo_fix = quo_s3 + 1'b1;
			rem_fix = rem_s3 - REM_W'(d0_s3);
		end else begin
			quo_fix = quo_s3;
			rem_fix = rem_s3;
		end
		word_c            = '0;
		word_c.mode       = mode_s3;
		word_c.cnt0       = CNT_W'(quo_fix);
		word_c.rest       = REST_W'(rem_fix);
		word_c.total      = CNT_W'(quo_fix);
		word_c.best_cnt   = (quo_fix > 2) ? 2'd3 : 2'(quo_fix);
		word_c.best_denom = (quo_fix != '0) ? d0_s3 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1   <= prod_c;
			amount_s1 <= amount;
			mode_s1   <= mode;
			quo_s2    <= quo_c;
			qd_s2     <= qd_c;
			amount_s2 <= amount_s1;
			mode_s2   <= mode_s1;
			quo_s3    <= quo_s2;
			rem_s3    <= REM_W'(diff_c);
			mode_s3   <= mode_s2;
			word_s4   <= word_c;
		end
	end

	assign v_out = v_s4;
	assign w_out = word_s4;

endmodule

### design/gcb_chain.sv
module gcb_chain import gcb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      v_in,
	input  gcb_word_t w_in,
	output logic      v_out,
	output gcb_word_t w_out
);

	function automatic gcb_word_t tally_step(
		input gcb_word_t         w,
		input logic [IDX_W-1:0]  pos,
		input logic [DEN_W-1:0]  d
	);
		gcb_word_t         r;
		logic [REST_W:0]   d1;
		logic [REST_W:0]   d2;
		logic [1:0]        c;
		r  = w;
		d1 = (REST_W+1)'(d);
		d2 = d1 << 1;
		if ({1'b0, w.rest} >= d2) begin
			c      = 2'd2;
			r.rest = REST_W'({1'b0, w.rest} - d2);
		end else if ({1'b0, w.rest} >= d1) begin
			c      = 2'd1;
			r.rest = REST_W'({1'b0, w.rest} - d1);
		end else begin
			c      = 2'd0;
		end
		r.cnt_small[pos] = c;
		r.total          = w.total + CNT_W'(c);
		if (c > w.best_cnt) begin
			r.best_cnt   = c;
			r.best_denom = d;
		end
		return r;
	endfunction

	gcb_word_t          word_s [N_SMALL];
	logic [N_SMALL-1:0] vld_s;
	gcb_word_t          cur    [N_SMALL];
	gcb_word_t          nxt    [N_SMALL];

	for (genvar k = 0; k < N_SMALL; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign cur[k] = w_in;
		end else begin : g_next
			assign cur[k] = word_s[k-1];
		end
		assign nxt[k] = tally_step(cur[k], IDX_W'(k), DENOM[k+1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[N_SMALL-2:0], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < N_SMALL; k++) begin
				word_s[k] <= nxt[k];
			end
		end
	end

	assign v_out = vld_s[N_SMALL-1];
	assign w_out = word_s[N_SMALL-1];

endmodule

### design/gcb_emit.sv
module gcb_emit import gcb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             v_in,
	input  gcb_word_t        w_in,
	output logic             take,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [DEN_W-1:0] denom_cents,
	output logic [CNT_W-1:0] piece_count,
	output logic             last_flag,
	output logic [CNT_W-1:0] total_pieces,
	output logic [DEN_W-1:0] most_frequent_cents
);

	logic                              busy_q;
	logic [NUM_DENOMS-1:0]             pend_q;
	logic [NUM_DENOMS-1:0][CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]                  total_q;
	logic [DEN_W-1:0]                  best_q;

	logic                              valid_q;
	logic [DEN_W-1:0]                  denom_q;
	logic [CNT_W-1:0]                  count_q;
	logic                              last_q;
	logic [CNT_W-1:0]                  tot_out_q;
	logic [DEN_W-1:0]                  most_q;

	logic [NUM_DENOMS-1:0][CNT_W-1:0]  tab;
	logic [NUM_DENOMS-1:0]             mask;
	logic [NUM_DENOMS-1:0]             lowbit;
	logic [DEN_W-1:0]                  sel_denom;
	logic [CNT_W-1:0]                  sel_count;
	logic                              is_last;
	logic                              out_adv;

	// place the incoming counts in table order
	always_comb begin
		for (int i = 0; i < NUM_DENOMS; i++) begin
			if (i == 0) begin
				tab[i] = w_in.mode ? w_in.cnt0 : '0;
			end else if (i == FIRST_COIN) begin
				tab[i] = w_in.mode ? CNT_W'(w_in.cnt_small[i-1]) : w_in.cnt0;
			end else begin
				tab[i] = CNT_W'(w_in.cnt_small[i-1]);
			end
			mask[i] = (tab[i] != '0);
		end
	end

	assign lowbit  = pend_q & (~pend_q + 1'b1);
	assign is_last = ((pend_q & ~lowbit) == '0);

	always_comb begin
		sel_denom = '0;
		sel_count = '0;
		for (int i = 0; i < NUM_DENOMS; i++) begin
			if (lowbit[i]) begin
				sel_denom = sel_denom | DENOM[i];
				sel_count = sel_count | cnt_q[i];
			end
		end
	end

	assign out_adv = !valid_q || !out_stall;
	assign take    = !busy_q || (out_adv && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pend_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (out_adv) begin
				valid_q <= busy_q;
			end
			if (take) begin
				busy_q <= v_in;
				pend_q <= mask;
			end else if (out_adv && busy_q) begin
				pend_q <= pend_q & ~lowbit;
				busy_q <= !is_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && v_in) begin
			cnt_q   <= tab;
			total_q <= w_in.total;
			best_q  <= w_in.best_denom;
		end
		if (out_adv && busy_q) begin
			denom_q   <= sel_denom;
			count_q   <= sel_count;
			last_q    <= is_last;
			tot_out_q <= is_last ? total_q : '0;
			most_q    <= is_last ? best_q : '0;
		end
	end

	assign out_valid           = valid_q;
	assign denom_cents         = denom_q;
	assign piece_count         = count_q;
	assign last_flag           = last_q;
	assign total_pieces        = tot_out_q;
	assign most_frequent_cents = most_q;

endmodule

### design/gcb_chk.sv
module gcb_chk import gcb_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic [AMOUNT_BITS-1:0] amount_cents,
	input logic                   mode,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [DEN_W-1:0]       denom_cents,
	input logic [CNT_W-1:0]       piece_count,
	input logic                   last_flag,
	input logic [CNT_W-1:0]       total_pieces,
	input logic [DEN_W-1:0]       most_frequent_cents
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(denom_cents)
			&& $stable(piece_count) && $stable(last_flag))
		else $error("stalled output word changed");

	// summary fields only on the final word
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_flag |-> total_pieces == '0 && most_frequent_cents == '0)
		else $error("summary on non-final word");

	// a word before the final one names a used denomination
	a_used_denom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_flag |-> piece_count != '0 && denom_cents != '0)
		else $error("empty denomination word");

	// zero amount word is empty throughout
	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_flag && denom_cents == '0 |->
			piece_count == '0 && total_pieces == '0 && most_frequent_cents == '0)
		else $error("zero word carries counts");

endmodule

bind greedy_change_breakdown_core gcb_chk u_chk (.*);
